/* src/tpmd_pkg.sv */
// Shared types and constants for the touch-pad matrix debouncer.
package tpmd_pkg;

   localparam int ROW_WIDTH      = 2;
   localparam int COL_BITS_WIDTH = 3;
   localparam int KEY_WIDTH      = 4;
   localparam int CSR_IDX_WIDTH  = 2;
   localparam int CFG_WIDTH      = 4;

   // Register indexes on the csr port
   localparam logic [CSR_IDX_WIDTH-1:0] REG_COUNT_FLOOR   = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_COUNT_CEILING = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_RELEASE_BELOW = 2'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_PRESS_ABOVE   = 2'd3;

   // Register reset values
   localparam logic [CFG_WIDTH-1:0] FLOOR_RESET   = 4'd2;
   localparam logic [CFG_WIDTH-1:0] CEILING_RESET = 4'd6;
   localparam logic [CFG_WIDTH-1:0] RELEASE_RESET = 4'd3;
   localparam logic [CFG_WIDTH-1:0] PRESS_RESET   = 4'd5;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] count_floor;
      logic [CFG_WIDTH-1:0] count_ceiling;
      logic [CFG_WIDTH-1:0] release_below;
      logic [CFG_WIDTH-1:0] press_above;
   } cfg_type;

endpackage

/* src/touch_pad_matrix_debouncer.sv */
// Top level of the touch-pad matrix debouncer: config registers, column lanes, merge, output buffer.
// Event words are registered: into the main register, or into the skid while the main one is held.
// Throughput: one scan per cycle while req_ready is high; the lanes read, update and write back the
// scanned row's counters in the accept cycle, so scans of the same row may follow back to back.
// Output: a main register plus a skid register; req_ready drops only while the skid is full.
// Reset (synchronous): config registers to floor 2, ceiling 6, release 3, press 5,
// every pad counter to the floor reset value, every pad released, output buffer empty.
module touch_pad_matrix_debouncer #(
   parameter int ROWS        = 3,
   parameter int COLS        = 3,
   parameter int COUNT_WIDTH = 4
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // scan words in
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [tpmd_pkg::ROW_WIDTH-1:0]       req_row,
   input  logic [tpmd_pkg::COL_BITS_WIDTH-1:0]  req_col_bits,
   // event words out
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_press_event,
   output logic [tpmd_pkg::KEY_WIDTH-1:0]       rsp_key_index,
   // register writes
   input  logic                                 csr_write_en,
   input  logic [tpmd_pkg::CSR_IDX_WIDTH-1:0]   csr_index,
   input  logic [tpmd_pkg::CFG_WIDTH-1:0]       csr_wdata
);

   localparam int RIDX_WIDTH = (ROWS > 1) ? $clog2(ROWS) : 1;

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   tpmd_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.count_floor   <= tpmd_pkg::FLOOR_RESET;
         cfg_ff.count_ceiling <= tpmd_pkg::CEILING_RESET;
         cfg_ff.release_below <= tpmd_pkg::RELEASE_RESET;
         cfg_ff.press_above   <= tpmd_pkg::PRESS_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            tpmd_pkg::REG_COUNT_FLOOR:   cfg_ff.count_floor   <= csr_wdata;
            tpmd_pkg::REG_COUNT_CEILING: cfg_ff.count_ceiling <= csr_wdata;
            tpmd_pkg::REG_RELEASE_BELOW: cfg_ff.release_below <= csr_wdata;
            tpmd_pkg::REG_PRESS_ABOVE:   cfg_ff.press_above   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Input handshake and row decode
   // ---------------------------------------------------------------
   logic                  push;
   logic                  pop;
   logic                  row_ok;
   logic                  lane_update;
   logic [RIDX_WIDTH-1:0] row_idx;

   assign push        = req_valid && req_ready;
   assign pop         = rsp_valid && rsp_ready;
   // a row beyond the matrix touches no state and yields an empty word
   assign row_ok      = int'(req_row) < ROWS;
   assign lane_update = push && row_ok;
   assign row_idx     = RIDX_WIDTH'(req_row);

   // ---------------------------------------------------------------
   // Column lanes: one integrator bank per column, all updated together
   // ---------------------------------------------------------------
   logic [COLS-1:0] lane_event;
   logic [COLS-1:0] lane_event_ok;

   for (genvar c = 0; c < COLS; c++) begin : g_lane
      logic touched;
      if (c < tpmd_pkg::COL_BITS_WIDTH) begin : g_sensed
         assign touched = req_col_bits[c];
      end else begin : g_unsensed
         // columns without a sense bit always count down
         assign touched = 1'b0;
      end

      tpmd_lane #(
         .ROWS        (ROWS),
         .COUNT_WIDTH (COUNT_WIDTH),
         .RIDX_WIDTH  (RIDX_WIDTH)
      ) u_lane (
         .clock       (clock),
         .reset       (reset),
         .update      (lane_update),
         .row_idx     (row_idx),
         .touched     (touched),
         .cfg         (cfg_ff),
         .press_event (lane_event[c])
      );
   end

   assign lane_event_ok = row_ok ? lane_event : '0;

   // ---------------------------------------------------------------
   // Merge: highest newly pressed pad of the row
   // ---------------------------------------------------------------
   logic                           merged_event;
   logic [tpmd_pkg::KEY_WIDTH-1:0] merged_key;

   tpmd_merge #(
      .COLS        (COLS)
   ) u_merge (
      .lane_event  (lane_event_ok),
      .row         (req_row),
      .press_event (merged_event),
      .key_index   (merged_key)
   );

   // ---------------------------------------------------------------
   // Output buffer: main register with a skid register behind it
   // ---------------------------------------------------------------
   logic                           main_valid_ff;
   logic                           main_event_ff;
   logic [tpmd_pkg::KEY_WIDTH-1:0] main_key_ff;
   logic                           skid_valid_ff;
   logic                           skid_event_ff;
   logic [tpmd_pkg::KEY_WIDTH-1:0] skid_key_ff;

   // take a new word whenever the skid is free
   assign req_ready = !skid_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         // advance the skid word into the main register once the head leaves
         if (pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (main_valid_ff && !pop) begin
            skid_valid_ff <= 1'b1;
         end else begin
            main_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         main_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            main_event_ff <= skid_event_ff;
            main_key_ff   <= skid_key_ff;
         end
      end else if (push) begin
         if (main_valid_ff && !pop) begin
            skid_event_ff <= merged_event;
            skid_key_ff   <= merged_key;
         end else begin
            main_event_ff <= merged_event;
            main_key_ff   <= merged_key;
         end
      end
   end

   assign rsp_valid       = main_valid_ff;
   assign rsp_press_event = main_event_ff;
   assign rsp_key_index   = main_key_ff;

endmodule

/* src/tpmd_lane.sv */
// One column lane: integrating counters and press flags for every row of one column.
module tpmd_lane #(
   parameter int ROWS        = 3,
   parameter int COUNT_WIDTH = 4,
   parameter int RIDX_WIDTH  = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  update,
   input  logic [RIDX_WIDTH-1:0] row_idx,
   input  logic                  touched,
   input  tpmd_pkg::cfg_type     cfg,
   output logic                  press_event
);

   localparam int EW = ((COUNT_WIDTH > tpmd_pkg::CFG_WIDTH) ?
                        COUNT_WIDTH : tpmd_pkg::CFG_WIDTH) + 1;
   localparam logic [COUNT_WIDTH-1:0] COUNT_RESET = COUNT_WIDTH'(tpmd_pkg::FLOOR_RESET);

   logic [COUNT_WIDTH-1:0] count_ff [ROWS];
   logic                   pressed_ff [ROWS];

   logic [COUNT_WIDTH-1:0] old_count;
   logic                   old_pressed;
   logic [EW-1:0]          sum;
   logic                   underflow;
   logic [EW-1:0]          floor_e;
   logic [EW-1:0]          ceil_e;
   logic [EW-1:0]          clamped;
   logic [COUNT_WIDTH-1:0] count_in;
   logic                   pressed_in;

   assign old_count   = count_ff[row_idx];
   assign old_pressed = pressed_ff[row_idx];
   assign floor_e     = EW'(cfg.count_floor);
   assign ceil_e      = EW'(cfg.count_ceiling);

   always_comb begin
      underflow = 1'b0;
      if (touched) begin
         sum = EW'(old_count) + EW'(1);
      end else if (old_count == '0) begin
         sum       = '0;
         underflow = 1'b1;
      end else begin
         sum = EW'(old_count) - EW'(1);
      end

      // floor first, ceiling second: ceiling wins when they cross
      clamped = (underflow || (sum < floor_e)) ? floor_e : sum;
      if (clamped > ceil_e) begin
         clamped = ceil_e;
      end
      count_in = clamped[COUNT_WIDTH-1:0];

      pressed_in  = old_pressed;
      press_event = 1'b0;
      if (EW'(count_in) < EW'(cfg.release_below)) begin
         pressed_in = 1'b0;
      end
      if ((EW'(count_in) > EW'(cfg.press_above)) && !pressed_in) begin
         pressed_in  = 1'b1;
         press_event = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < ROWS; r++) begin
            count_ff[r]   <= COUNT_RESET;
            pressed_ff[r] <= 1'b0;
         end
      end else if (update) begin
         count_ff[row_idx]   <= count_in;
         pressed_ff[row_idx] <= pressed_in;
      end
   end

endmodule

/* src/tpmd_merge.sv */
// Merge stage: picks the highest column that reported a new press and forms its key index.
module tpmd_merge #(
   parameter int COLS = 3
) (
   input  logic [COLS-1:0]                    lane_event,
   input  logic [tpmd_pkg::ROW_WIDTH-1:0]     row,
   output logic                               press_event,
   output logic [tpmd_pkg::KEY_WIDTH-1:0]     key_index
);

   localparam int CIDX_WIDTH = (COLS > 1) ? $clog2(COLS) : 1;

   logic [CIDX_WIDTH-1:0] col_sel;

   always_comb begin
      col_sel     = '0;
      press_event = 1'b0;
      for (int c = 0; c < COLS; c++) begin
         if (lane_event[c]) begin
            col_sel     = CIDX_WIDTH'(c);
            press_event = 1'b1;
         end
      end
      key_index = '0;
      if (press_event) begin
         key_index = tpmd_pkg::KEY_WIDTH'(int'(row) * COLS + int'(col_sel));
      end
   end

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the touch-pad matrix debouncer: directed script, then random scans.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PAD_ROWS        = 3;
   localparam int PAD_COLS        = 3;
   localparam int LEVEL_WIDTH     = 4;
   localparam int PAD_TOTAL       = PAD_ROWS * PAD_COLS;
   localparam int PHASES          = 6;
   localparam int SCANS_PER_PHASE = 165;
   localparam int DRAIN_CYCLES    = 8;
   localparam int unsigned CYCLE_LIMIT = 200000;

   // Kinds of step in the directed script
   localparam logic ROW_SCAN  = 1'b0;
   localparam logic REG_WRITE = 1'b1;

   typedef logic [tpmd_pkg::ROW_WIDTH-1:0]      row_type;
   typedef logic [tpmd_pkg::COL_BITS_WIDTH-1:0] col_bits_type;
   typedef logic [tpmd_pkg::CFG_WIDTH-1:0]      cfg_field_type;

   typedef struct packed {
      logic                           kind;
      logic [1:0]                     sel;       // row for a scan, register index for a write
      logic [3:0]                     val;       // column bits for a scan, data for a write
      logic                           has_exp;   // expectation typed in below
      logic                           exp_event;
      logic [tpmd_pkg::KEY_WIDTH-1:0] exp_key;
   } step_type;

   typedef struct packed {
      logic                           press_event;
      logic [tpmd_pkg::KEY_WIDTH-1:0] key_index;
   } key_report_type;

   // Ports of the block, every input known from time zero
   logic                                clock        = 1'b0;
   logic                                reset        = 1'b1;
   logic                                req_valid    = 1'b0;
   logic                                req_ready;
   logic [tpmd_pkg::ROW_WIDTH-1:0]      req_row      = '0;
   logic [tpmd_pkg::COL_BITS_WIDTH-1:0] req_col_bits = '0;
   logic                                rsp_valid;
   logic                                rsp_ready    = 1'b0;
   logic                                rsp_press_event;
   logic [tpmd_pkg::KEY_WIDTH-1:0]      rsp_key_index;
   logic                                csr_write_en = 1'b0;
   logic [tpmd_pkg::CSR_IDX_WIDTH-1:0]  csr_index    = '0;
   logic [tpmd_pkg::CFG_WIDTH-1:0]      csr_wdata    = '0;

   // Mirror of the block: live register settings, pad integrators and press latches
   tpmd_pkg::cfg_type      live_cfg;
   logic [LEVEL_WIDTH-1:0] pad_level   [PAD_TOTAL];
   bit                     pad_latched [PAD_TOTAL];

   // Event words still owed by the block, oldest first
   key_report_type awaited_reports [$];

   int unsigned fault_count = 0;
   int unsigned cycle_count = 0;
   int unsigned sender_gap_pct     = 18;
   int unsigned receiver_stall_pct = 52;

   // Directed script. Expectations are typed in only where they are plain from the
   // settings at hand; every other scan is checked against the mirror.
   step_type script [0:35] = '{
      // reset settings (floor 2, ceiling 6, release 3, press 5): climb row 0 to a press
      '{ROW_SCAN,  2'd0, 4'd7, 1'b0, 1'b0, 4'd0},
      '{ROW_SCAN,  2'd0, 4'd7, 1'b0, 1'b0, 4'd0},
      '{ROW_SCAN,  2'd0, 4'd7, 1'b0, 1'b0, 4'd0},
      '{ROW_SCAN,  2'd0, 4'd7, 1'b1, 1'b1, 4'd2},
      // held at the ceiling, already pressed: no new event
      '{ROW_SCAN,  2'd0, 4'd7, 1'b1, 1'b0, 4'd0},
      // row out of range: no state change, empty word
      '{ROW_SCAN,  2'd3, 4'd7, 1'b1, 1'b0, 4'd0},
      '{ROW_SCAN,  2'd3, 4'd0, 1'b1, 1'b0, 4'd0},
      // outer columns of row 2 pressed together, highest index reported
      '{ROW_SCAN,  2'd2, 4'd5, 1'b0, 1'b0, 4'd0},
      '{ROW_SCAN,  2'd2, 4'd5, 1'b0, 1'b0, 4'd0},
      '{ROW_SCAN,  2'd2, 4'd5, 1'b0, 1'b0, 4'd0},
      '{ROW_SCAN,  2'd2, 4'd5, 1'b1, 1'b1, 4'd8},
      // let go of row 0 down to the floor, released on the way
      '{ROW_SCAN,  2'd0, 4'd0, 1'b0, 1'b0, 4'd0},
      '{ROW_SCAN,  2'd0, 4'd0, 1'b0, 1'b0, 4'd0},
      '{ROW_SCAN,  2'd0, 4'd0, 1'b0, 1'b0, 4'd0},
      '{ROW_SCAN,  2'd0, 4'd0, 1'b0, 1'b0, 4'd0},
      // floor above ceiling, counters left below the raised floor, release above press
      '{REG_WRITE, tpmd_pkg::REG_COUNT_FLOOR,   4'd9,  1'b0, 1'b0, 4'd0},
      '{REG_WRITE, tpmd_pkg::REG_COUNT_CEILING, 4'd4,  1'b0, 1'b0, 4'd0},
      '{REG_WRITE, tpmd_pkg::REG_RELEASE_BELOW, 4'd15, 1'b0, 1'b0, 4'd0},
      '{REG_WRITE, tpmd_pkg::REG_PRESS_ABOVE,   4'd0,  1'b0, 1'b0, 4'd0},
      '{ROW_SCAN,  2'd1, 4'd1, 1'b0, 1'b0, 4'd0},
      '{ROW_SCAN,  2'd1, 4'd6, 1'b0, 1'b0, 4'd0},
      // widest window: a press can never be reached, a release never made
      '{REG_WRITE, tpmd_pkg::REG_COUNT_FLOOR,   4'd0,  1'b0, 1'b0, 4'd0},
      '{REG_WRITE, tpmd_pkg::REG_COUNT_CEILING, 4'd15, 1'b0, 1'b0, 4'd0},
      '{REG_WRITE, tpmd_pkg::REG_RELEASE_BELOW, 4'd0,  1'b0, 1'b0, 4'd0},
      '{REG_WRITE, tpmd_pkg::REG_PRESS_ABOVE,   4'd15, 1'b0, 1'b0, 4'd0},
      '{ROW_SCAN,  2'd1, 4'd7, 1'b0, 1'b0, 4'd0},
      '{ROW_SCAN,  2'd2, 4'd2, 1'b0, 1'b0, 4'd0},
      '{ROW_SCAN,  2'd0, 4'd0, 1'b0, 1'b0, 4'd0},
      // narrowest window at the top of the range: each step between 14 and 15 toggles the latch
      '{REG_WRITE, tpmd_pkg::REG_COUNT_FLOOR,   4'd14, 1'b0, 1'b0, 4'd0},
      '{REG_WRITE, tpmd_pkg::REG_COUNT_CEILING, 4'd15, 1'b0, 1'b0, 4'd0},
      '{REG_WRITE, tpmd_pkg::REG_RELEASE_BELOW, 4'd15, 1'b0, 1'b0, 4'd0},
      '{REG_WRITE, tpmd_pkg::REG_PRESS_ABOVE,   4'd14, 1'b0, 1'b0, 4'd0},
      '{ROW_SCAN,  2'd0, 4'd7, 1'b0, 1'b0, 4'd0},
      '{ROW_SCAN,  2'd0, 4'd7, 1'b0, 1'b0, 4'd0},
      '{ROW_SCAN,  2'd0, 4'd3, 1'b0, 1'b0, 4'd0},
      '{ROW_SCAN,  2'd0, 4'd4, 1'b0, 1'b0, 4'd0}
   };

   touch_pad_matrix_debouncer #(
      .ROWS        (PAD_ROWS),
      .COLS        (PAD_COLS),
      .COUNT_WIDTH (LEVEL_WIDTH)
   ) uut (.*);

   always #5 clock = ~clock;

   // Integrate one row scan into the mirror and return the event word it should cause.
   // Floor clamp before ceiling clamp, release test before press test.
   function automatic key_report_type debounce_scan(input row_type      row,
                                                    input col_bits_type bits);
      key_report_type rep;
      int             idx;
      int             lvl;
      int             c;
      rep = '0;
      if (row < PAD_ROWS) begin
         for (c = 0; c < PAD_COLS; c++) begin
            idx = row * PAD_COLS + c;
            lvl = int'(pad_level[idx]) + (bits[c] ? 1 : -1);
            if (lvl < int'(live_cfg.count_floor))   lvl = int'(live_cfg.count_floor);
            if (lvl > int'(live_cfg.count_ceiling)) lvl = int'(live_cfg.count_ceiling);
            pad_level[idx] = lvl[LEVEL_WIDTH-1:0];
            if (pad_level[idx] < live_cfg.release_below) pad_latched[idx] = 1'b0;
            if (pad_level[idx] > live_cfg.press_above && !pad_latched[idx]) begin
               pad_latched[idx]  = 1'b1;
               rep.press_event   = 1'b1;
               rep.key_index     = idx[tpmd_pkg::KEY_WIDTH-1:0];
            end
         end
      end
      return rep;
   endfunction

   // Offer one scan word, idling first at the current sender rate, and hold it until
   // taken. On acceptance advance the mirror and queue the owed event word.
   task automatic send_scan(input row_type        row,
                            input col_bits_type   bits,
                            input bit             has_exp,
                            input key_report_type typed);
      key_report_type predicted;
      csr_write_en <= 1'b0;
      while ($urandom_range(0, 99) < sender_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_row      <= row;
      req_col_bits <= bits;
      do @(posedge clock); while (!req_ready);
      predicted = debounce_scan(row, bits);
      awaited_reports.push_back(has_exp ? typed : predicted);
   endtask

   // Drop valid and hold off until every owed event word has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (awaited_reports.size() != 0) @(posedge clock);
   endtask

   // Write one register; the enable is dropped by the next scan.
   task automatic write_reg(input logic [tpmd_pkg::CSR_IDX_WIDTH-1:0] idx,
                            input cfg_field_type                      data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
      case (idx)
         tpmd_pkg::REG_COUNT_FLOOR:   live_cfg.count_floor   = data;
         tpmd_pkg::REG_COUNT_CEILING: live_cfg.count_ceiling = data;
         tpmd_pkg::REG_RELEASE_BELOW: live_cfg.release_below = data;
         tpmd_pkg::REG_PRESS_ABOVE:   live_cfg.press_above   = data;
         default: ;
      endcase
   endtask

   // Event word side: check each accepted word against the oldest owed one, then
   // decide whether to stall the next edge.
   always @(posedge clock) begin
      key_report_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_reports.size() == 0) begin
            $display("%0t ns: event word with none owed: expected nothing, got event %0b key %0d",
                     $time, rsp_press_event, rsp_key_index);
            fault_count++;
         end else begin
            want = awaited_reports.pop_front();
            if (rsp_press_event !== want.press_event) begin
               $display("%0t ns: press_event mismatch: expected %0b, got %0b",
                        $time, want.press_event, rsp_press_event);
               fault_count++;
            end
            if (rsp_key_index !== want.key_index) begin
               $display("%0t ns: key_index mismatch: expected %0d, got %0d",
                        $time, want.key_index, rsp_key_index);
               fault_count++;
            end
         end
      end
      rsp_ready   <= ($urandom_range(0, 99) >= receiver_stall_pct);
      cycle_count <= cycle_count + 1;
   end

   // Watchdog: give up well past the slowest legal run.
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("%0t ns: no finish after %0d cycles", $time, CYCLE_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      col_bits_type      held [PAD_ROWS];
      row_type           row;
      col_bits_type      bits;
      col_bits_type      noise;
      tpmd_pkg::cfg_type phase_cfg;
      key_report_type    typed;
      int                scan_row;
      int                scans;
      bit                paused;

      // Mirror starts where the block's reset leaves it: every pad at the floor, released
      live_cfg = '{tpmd_pkg::FLOOR_RESET, tpmd_pkg::CEILING_RESET,
                   tpmd_pkg::RELEASE_RESET, tpmd_pkg::PRESS_RESET};
      for (int k = 0; k < PAD_TOTAL; k++) begin
         pad_level[k]   = tpmd_pkg::FLOOR_RESET;
         pad_latched[k] = 1'b0;
      end
      for (int r = 0; r < PAD_ROWS; r++) held[r] = '0;
      scan_row = 0;

      // Hold reset, once only
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed script; register writes only with nothing in flight
      foreach (script[i]) begin
         if (script[i].kind == REG_WRITE) begin
            wait_drained();
            write_reg(script[i].sel, script[i].val);
         end else begin
            typed = {script[i].exp_event, script[i].exp_key};
            send_scan(script[i].sel, script[i].val[tpmd_pkg::COL_BITS_WIDTH-1:0],
                      script[i].has_exp, typed);
         end
      end

      // Random phases. Most words are a steady row-by-row scan of a slowly changing
      // touch pattern with the odd flicker; a few are stray words with any row, the
      // out-of-range row among them.
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase / 2)
            0:       begin sender_gap_pct = 18; receiver_stall_pct = 52; end
            1:       begin sender_gap_pct = 52; receiver_stall_pct = 18; end
            default: begin sender_gap_pct = 0;  receiver_stall_pct = 0;  end
         endcase

         case (phase)
            0:       phase_cfg = '{tpmd_pkg::FLOOR_RESET, tpmd_pkg::CEILING_RESET,
                                   tpmd_pkg::RELEASE_RESET, tpmd_pkg::PRESS_RESET};
            1:       phase_cfg = '{4'd0, 4'd15, 4'd7, 4'd8};
            2:       phase_cfg = '{4'd14, 4'd15, 4'd15, 4'd14};
            3:       phase_cfg = '{4'd0, 4'd1, 4'd1, 4'd0};
            default: begin
               phase_cfg.count_ceiling = cfg_field_type'($urandom_range(1, 15));
               phase_cfg.count_floor   =
                  cfg_field_type'($urandom_range(0, phase_cfg.count_ceiling - 1));
               phase_cfg.press_above   =
                  cfg_field_type'($urandom_range(0, phase_cfg.count_ceiling - 1));
               phase_cfg.release_below = cfg_field_type'($urandom_range(0, 15));
            end
         endcase

         wait_drained();
         write_reg(tpmd_pkg::REG_COUNT_FLOOR,   phase_cfg.count_floor);
         write_reg(tpmd_pkg::REG_COUNT_CEILING, phase_cfg.count_ceiling);
         write_reg(tpmd_pkg::REG_RELEASE_BELOW, phase_cfg.release_below);
         write_reg(tpmd_pkg::REG_PRESS_ABOVE,   phase_cfg.press_above);

         scans  = 0;
         paused = 1'b0;
         while (scans < SCANS_PER_PHASE) begin
            // Halfway through, hold the sender until the block has emptied
            if (!paused && scans == SCANS_PER_PHASE / 2) begin
               wait_drained();
               paused = 1'b1;
            end

            // Now and then a finger lands on or leaves some row
            if ($urandom_range(0, 31) == 0)
               held[$urandom_range(0, PAD_ROWS - 1)] = col_bits_type'($urandom_range(0, 7));

            if ($urandom_range(0, 19) == 0) begin
               row  = row_type'($urandom_range(0, 3));
               bits = col_bits_type'($urandom_range(0, 7));
            end else begin
               noise = ($urandom_range(0, 3) == 0) ? (3'b001 << $urandom_range(0, 2)) : 3'b000;
               row   = row_type'(scan_row);
               bits  = held[scan_row] ^ noise;
               scan_row = (scan_row + 1) % PAD_ROWS;
            end

            send_scan(row, bits, 1'b0, '0);
            if (row < PAD_ROWS) scans++;
         end
      end

      // Drain, then wait on so that any stray word shows, then judge
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
